// ===== sv/sobel_pkg.sv =====
// Shared constants and types for the Sobel edge threshold block.
package sobel_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4095;
  localparam int MIN_SIZE   = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int CFG_W      = 12;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET     = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET    = CFG_W'(480);
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(200);
  localparam logic [PIX_W-1:0] MAG_MAX         = PIX_W'(255);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_idx_t;

  function automatic sum_t weighted_sum(pix_t a, pix_t b, pix_t c);
    weighted_sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  function automatic sum_t abs_diff(sum_t p, sum_t n);
    abs_diff = (p >= n) ? (p - n) : (n - p);
  endfunction

endpackage

// ===== sv/sobel_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module sobel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sobel_edge_threshold.sv =====
// Top level of the streaming 3x3 Sobel edge detector with threshold.
// A pixel is registered in stage 1 and its result in the output register; one pixel per
// clock unless the output stalls. The line stores use one write and one read port each.
// Border pixels give no result, so a frame yields (width-2)*(height-2) results.
// Reset (rst_n low, synchronous) clears the position, window, pipeline valids and
// loads the register defaults; the line stores hold unknown data until written.
module sobel_edge_threshold
  import sobel_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] edge_magnitude, [19:8] center_row,
                                  // [30:20] center_col, [31] zero
  output logic        out_tuser,  // [0] edge_flag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfg_t width_r, height_r;
  pix_t thresh_r;

  col_t col_r, col_nxt;
  row_t row_r, row_nxt;

  logic s1_valid_r;
  pix_t s1_pix_r;
  col_t s1_col_r;
  row_t s1_row_r;
  logic fwd_r;
  pix_t fwd_upper_r, fwd_middle_r;

  pix_t win_r [6];

  logic out_valid_r;
  pix_t out_mag_r;
  logic out_flag_r;
  row_t out_row_r;
  col_t out_col_r;

  logic in_acc, s1_adv, s1_emit;
  col_t c_in;
  row_t r_in;
  cfg_t w_use, h_use;
  pix_t upper_q, middle_q, top, mid, bot;
  sum_t gy, gx;
  logic [SUM_W:0] mag_full;
  pix_t mag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      thresh_r <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    width_r  <= cfg_data;
        REG_IMAGE_HEIGHT:   height_r <= cfg_data;
        REG_EDGE_THRESHOLD: thresh_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < CFG_W'(MIN_SIZE)) begin
      w_use = CFG_W'(MIN_SIZE);
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      w_use = CFG_W'(MAX_WIDTH);
    end else begin
      w_use = width_r;
    end
    if (height_r < CFG_W'(MIN_SIZE)) begin
      h_use = CFG_W'(MIN_SIZE);
    end else if (height_r > CFG_W'(MAX_HEIGHT)) begin
      h_use = CFG_W'(MAX_HEIGHT);
    end else begin
      h_use = height_r;
    end
  end

  assign s1_emit   = (s1_row_r >= ROW_W'(2)) && (s1_col_r >= COL_W'(2));
  assign s1_adv    = s1_valid_r && (!s1_emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign c_in = in_tuser ? '0 : col_r;
  assign r_in = in_tuser ? '0 : row_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if ({{(CFG_W-COL_W){1'b0}}, c_in} >= w_use - CFG_W'(1)) begin
        col_nxt = '0;
        row_nxt = (r_in >= h_use - CFG_W'(1)) ? '0 : r_in + ROW_W'(1);
      end else begin
        col_nxt = c_in + COL_W'(1);
        row_nxt = r_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (mid),
    .re    (in_acc),
    .raddr (c_in),
    .rdata (upper_q)
  );

  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (bot),
    .re    (in_acc),
    .raddr (c_in),
    .rdata (middle_q)
  );

  // A read at the column being written in the same cycle takes the new data.
  assign top = fwd_r ? fwd_upper_r  : upper_q;
  assign mid = fwd_r ? fwd_middle_r : middle_q;
  assign bot = s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= in_tdata;
      s1_col_r     <= c_in;
      s1_row_r     <= r_in;
      fwd_r        <= s1_adv && (s1_col_r == c_in);
      fwd_upper_r  <= mid;
      fwd_middle_r <= bot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

  assign gy = abs_diff(weighted_sum(win_r[2], win_r[5], bot),
                       weighted_sum(win_r[0], win_r[3], top));
  assign gx = abs_diff(weighted_sum(top, mid, bot),
                       weighted_sum(win_r[0], win_r[1], win_r[2]));
  assign mag_full = {1'b0, gx} + {1'b0, gy};
  assign mag = (mag_full > (SUM_W+1)'(MAG_MAX)) ? MAG_MAX : mag_full[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_mag_r  <= mag;
      out_flag_r <= mag > thresh_r;
      out_row_r  <= s1_row_r - ROW_W'(1);
      out_col_r  <= s1_col_r - COL_W'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_col_r, out_row_r, out_mag_r};
  assign out_tuser  = out_flag_r;

endmodule

// ===== tb/sobel_edge_checker.sv =====
// Checker that predicts the Sobel edge results of the observed requests and compares them.
module sobel_edge_checker
  import sobel_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  input  logic        in_tuser,   // [0] frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [7:0] edge_magnitude, [19:8] center_row,
                                  // [30:20] center_col, [31] zero
  input  logic        out_tuser,  // [0] edge_flag
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          mismatch_count,
  output int          edges_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pix_t magnitude;
    logic is_edge;
    row_t row;
    col_t col;
  } edge_result_t;

  cfg_t width_reg;
  cfg_t height_reg;
  pix_t threshold_reg;
  pix_t upper_line [MAX_WIDTH];
  pix_t middle_line [MAX_WIDTH];
  pix_t window [6];
  col_t col_pos;
  row_t row_pos;
  edge_result_t expected_edges [$];

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic predict_edge(input pix_t pix, input logic frame_start);
    int used_w, used_h, c, r;
    int lt, lm, lb, ct, cb, top, mid, bot, gy, gx, mag;
    edge_result_t res;
    used_w = int'(width_reg);
    if (used_w < MIN_SIZE) used_w = MIN_SIZE;
    if (used_w > MAX_WIDTH) used_w = MAX_WIDTH;
    used_h = int'(height_reg);
    if (used_h < MIN_SIZE) used_h = MIN_SIZE;
    if (used_h > MAX_HEIGHT) used_h = MAX_HEIGHT;
    if (frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    c = int'(col_pos);
    r = int'(row_pos);
    top = int'(upper_line[c]);
    mid = int'(middle_line[c]);
    bot = int'(pix);
    if (r >= 2 && c >= 2) begin
      lt = int'(window[0]);
      lm = int'(window[1]);
      lb = int'(window[2]);
      ct = int'(window[3]);
      cb = int'(window[5]);
      gy = (lb + 2 * cb + bot) - (lt + 2 * ct + top);
      gx = (top + 2 * mid + bot) - (lt + 2 * lm + lb);
      if (gy < 0) gy = -gy;
      if (gx < 0) gx = -gx;
      mag = gx + gy;
      if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
      res.magnitude = pix_t'(mag);
      res.is_edge   = (mag > int'(threshold_reg));
      res.row       = row_t'(r - 1);
      res.col       = col_t'(c - 1);
      expected_edges.push_back(res);
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = pix_t'(top);
    window[4] = pix_t'(mid);
    window[5] = pix;
    upper_line[c]  = pix_t'(mid);
    middle_line[c] = pix;
    if (c >= used_w - 1) begin
      col_pos = '0;
      row_pos = (r >= used_h - 1) ? row_t'(0) : row_t'(r + 1);
    end else begin
      col_pos = col_t'(c + 1);
    end
  endtask

  task automatic check_result();
    edge_result_t want;
    if (expected_edges.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: row %0d col %0d magnitude %0d",
                                out_tdata[19:8], out_tdata[30:20], out_tdata[7:0]));
    end else begin
      want = expected_edges.pop_front();
      if (out_tdata[7:0] !== want.magnitude)
        report_mismatch($sformatf("magnitude %0d, expected %0d at row %0d col %0d",
                                  out_tdata[7:0], want.magnitude, want.row, want.col));
      if (out_tuser !== want.is_edge)
        report_mismatch($sformatf("edge flag %0b, expected %0b at row %0d col %0d",
                                  out_tuser, want.is_edge, want.row, want.col));
      if (out_tdata[19:8] !== want.row)
        report_mismatch($sformatf("centre row %0d, expected %0d", out_tdata[19:8], want.row));
      if (out_tdata[30:20] !== want.col)
        report_mismatch($sformatf("centre column %0d, expected %0d", out_tdata[30:20], want.col));
      if (out_tdata[31] !== 1'b0)
        report_mismatch($sformatf("padding bit %0b, expected 0", out_tdata[31]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg     = WIDTH_RESET;
      height_reg    = HEIGHT_RESET;
      threshold_reg = THRESHOLD_RESET;
      col_pos       = '0;
      row_pos       = '0;
      for (int i = 0; i < 6; i++) window[i] = '0;
      expected_edges.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) predict_edge(in_tdata, in_tuser);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: width_reg = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          REG_EDGE_THRESHOLD: threshold_reg = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
    end
    edges_pending = expected_edges.size();
  end

endmodule

// ===== tb/tb_sobel_edge_threshold.sv =====
// Top-level testbench for the Sobel edge threshold block: stimulus, receiver and verdict.
module tb_sobel_edge_threshold
  import sobel_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_PIXELS = 820;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // The first frame follows reset without a frame start, the second wraps the row count
  // and the third restarts with a frame start.
  localparam pix_t DIRECTED_PIX [27] = '{
    8'd0,  8'd0,  8'd0,   8'd0, 8'd0, 8'd0,   8'd255, 8'd255, 8'd255,
    8'd0,  8'd0,  8'd0,   8'd7, 8'd7, 8'd7,   8'd50,  8'd50,  8'd50,
    8'd0,  8'd0,  8'd1,   8'd0, 8'd0, 8'd0,   8'd50,  8'd50,  8'd51
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [11:0] cfg_data   = '0;
  logic        hold_start = 1'b0;

  int mismatch_count;
  int edges_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left;
  int pixels_sent = 0;
  int cycle_count;

  sobel_edge_threshold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sobel_edge_checker edge_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .edges_pending  (edges_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_start) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int used_size(input int value, input int upper);
    if (value < MIN_SIZE) return MIN_SIZE;
    if (value > upper) return upper;
    return value;
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  task automatic send_pixel(input pix_t pix, input logic frame_start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= frame_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_frame(input int cols, input int count, input logic restart);
    int style, base, amp;
    pix_t pix;
    style = $urandom_range(3);
    base  = $urandom_range(255);
    amp   = $urandom_range(40, 1);
    for (int n = 0; n < count; n++) begin
      case (style)
        0: pix = pix_t'($urandom);
        1: pix = pix_t'(base + $urandom_range(amp));
        2: pix = ($urandom_range(1) != 0) ? MAG_MAX : pix_t'(0);
        default: pix = pix_t'(base + (n % cols) * amp / 4 + $urandom_range(2));
      endcase
      send_pixel(pix, restart && n == 0);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (edges_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input cfg_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_image(input cfg_t cols, input cfg_t rows, input cfg_t threshold);
    write_reg(REG_IMAGE_WIDTH, cols);
    write_reg(REG_IMAGE_HEIGHT, rows);
    write_reg(REG_EDGE_THRESHOLD, threshold);
  endtask

  task automatic hold_receiver();
    in_tvalid  <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
  endtask

  initial begin
    cfg_t w_reg, h_reg, thr_reg;
    int phase_no, random_base, eff_w, eff_h, total, cut_at, frames;
    logic restart;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_IMAGE_WIDTH, cfg_t'(3));
    write_reg(REG_IMAGE_HEIGHT, cfg_t'(3));
    for (int n = 0; n < 27; n++) send_pixel(DIRECTED_PIX[n], n == 18);

    wait_drained();
    set_image(cfg_t'(0), cfg_t'(0), cfg_t'(0));
    write_reg(REG_UNUSED, cfg_t'(12'hFFF));
    for (int f = 0; f < 4; f++) begin
      set_idle(f);
      send_frame(3, 9, f == 0);
    end

    // Narrowing the width part-way through a row sends the column past the new width.
    wait_drained();
    set_image(cfg_t'(10), cfg_t'(8), cfg_t'(100));
    set_idle(3);
    send_frame(10, 36, 1'b1);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, cfg_t'(4));
    send_frame(4, 21, 1'b0);

    wait_drained();
    set_image(cfg_t'(32), cfg_t'(8), cfg_t'(60));
    set_idle(0);
    hold_receiver();
    send_frame(32, 256, 1'b1);

    wait_drained();
    set_image(cfg_t'(6), cfg_t'(4095), cfg_t'(40));
    set_idle(1);
    send_frame(6, 60, 1'b1);

    random_base = pixels_sent;
    phase_no = 0;
    while (pixels_sent - random_base < RANDOM_PIXELS) begin
      case ($urandom_range(9))
        0: w_reg = cfg_t'($urandom_range(2));
        1: w_reg = cfg_t'($urandom_range(64, 17));
        default: w_reg = cfg_t'($urandom_range(16, 3));
      endcase
      h_reg = ($urandom_range(9) == 0) ? cfg_t'($urandom_range(2)) : cfg_t'($urandom_range(7, 3));
      case ($urandom_range(6))
        0: thr_reg = cfg_t'(0);
        1: thr_reg = cfg_t'(255);
        default: thr_reg = cfg_t'($urandom_range(255));
      endcase
      wait_drained();
      set_image(w_reg, h_reg, thr_reg);
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, cfg_t'($urandom));
      set_idle(phase_no % 4);
      if ($urandom_range(7) == 0) hold_receiver();
      eff_w = used_size(int'(w_reg), MAX_WIDTH);
      eff_h = used_size(int'(h_reg), MAX_HEIGHT);
      total = eff_w * eff_h;
      frames = $urandom_range(3, 1);
      restart = 1'b1;
      for (int f = 0; f < frames; f++) begin
        cut_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1, 1) : total;
        send_frame(eff_w, cut_at, restart);
        restart = (cut_at < total) ? 1'b1 : logic'($urandom_range(1));
      end
      phase_no++;
    end

    // An oversized width register is clamped to the line store size.
    wait_drained();
    set_image(cfg_t'(4095), cfg_t'(3), cfg_t'(255));
    set_idle(0);
    send_frame(MAX_WIDTH, 96, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && edges_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sobel_edge_threshold.f =====
sv/sobel_pkg.sv
sv/sobel_ram.sv
sv/sobel_edge_threshold.sv
tb/sobel_edge_checker.sv
tb/tb_sobel_edge_threshold.sv
